// File: hw/rtl/marker_scan_codon_translator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the marker scan codon translator
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ---------------------------------------------------------------------------
`ifndef MARKER_SCAN_CODON_TRANSLATOR_ASSERT_SVH
`define MARKER_SCAN_CODON_TRANSLATOR_ASSERT_SVH

// Same-cycle implication.
`define MSCAN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define MSCAN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/mscan_pkg.sv
// ---------------------------------------------------------------------------
// Marker scan codon translator package
// Shared types, codes and the standard genetic code table.
// ---------------------------------------------------------------------------
package mscan_pkg;

	localparam logic [2:0] BASE_OTHER = 3'd4;

	localparam logic [4:0] AMINO_STOP    = 5'd20;
	localparam logic [4:0] AMINO_UNKNOWN = 5'd21;

	// Configuration register word index.
	localparam logic REG_MARKER_PATTERN = 1'b0;

	localparam logic [15:0] MARKER_RESET = 16'h0AC5;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_TRANSLATE,
		PH_STOPPED
	} phase_t;

	// Per-base control that the top level hands to the window and codon units.
	typedef struct packed {
		logic win_shift;
		logic codon_step;
		logic clear;
	} step_ctl_t;

	// Index is first*16 + second*4 + third with A0 C1 G2 T3.
	localparam logic [4:0] CODON_TABLE [64] = '{
		5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
		5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
		5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
		5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
		5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
		5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
		5'd20, 5'd1,  5'd18, 5'd1,  5'd9,  5'd4,  5'd9,  5'd4
	};

endpackage

// File: hw/rtl/mscan_window.sv
// ---------------------------------------------------------------------------
// Marker window
// Holds the most recent bases of the read and flags a marker match.
// ---------------------------------------------------------------------------
module mscan_window #(
	parameter int MARKER_LENGTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mscan_pkg::step_ctl_t ctl,
	input  logic [2:0]          base,
	input  logic [15:0]         marker_pattern,
	output logic                match
);
	import mscan_pkg::*;

	localparam int FILL_W = $clog2(MARKER_LENGTH + 1);

	logic [2:0]               window_q   [MARKER_LENGTH];
	logic [2:0]               window_nxt [MARKER_LENGTH];
	logic [FILL_W-1:0]        fill_q;
	logic [MARKER_LENGTH-1:0] hit;
	logic                     full_after;

	// The window after this base is shifted in; the match looks at that view.
	for (genvar i = 0; i < MARKER_LENGTH; i++) begin : g_tap
		localparam int POS = 2 * (MARKER_LENGTH - 1 - i);
		logic [1:0] mbase;

		if (i < MARKER_LENGTH - 1) begin : g_mid
			assign window_nxt[i] = window_q[i + 1];
		end else begin : g_new
			assign window_nxt[i] = base;
		end

		// Marker bases beyond the register width read as A.
		if (POS < 16) begin : g_reg
			assign mbase = marker_pattern[POS +: 2];
		end else begin : g_pad
			assign mbase = 2'b00;
		end

		assign hit[i] = (window_nxt[i] == {1'b0, mbase});
	end

	assign full_after = (fill_q >= FILL_W'(MARKER_LENGTH - 1));
	assign match      = full_after && (&hit);

	always_ff @(posedge clk) begin
		if (ctl.win_shift) begin
			window_q <= window_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.win_shift && (fill_q != FILL_W'(MARKER_LENGTH))) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

endmodule

// File: hw/rtl/mscan_codon.sv
// ---------------------------------------------------------------------------
// Codon assembler
// Collects three bases and translates them with the standard genetic code.
// ---------------------------------------------------------------------------
module mscan_codon (
	input  logic                clk,
	input  logic                arst_n,
	input  mscan_pkg::step_ctl_t ctl,
	input  logic [2:0]          base,
	output logic                amino_valid,
	output logic [4:0]          amino_code
);
	import mscan_pkg::*;

	logic [2:0] first_q;
	logic [2:0] second_q;
	logic [1:0] pos_q;
	logic       is_third;

	// The flag says that the next stepped base completes the codon. It does
	// not depend on the step itself, so the caller can decide whether the
	// base has to wait for the result register before it steps.
	assign is_third    = (pos_q == 2'd2);
	assign amino_valid = is_third;

	always_comb begin
		if (!is_third) begin
			amino_code = '0;
		end else if (first_q[2] || second_q[2] || base[2]) begin
			amino_code = AMINO_UNKNOWN;
		end else begin
			amino_code = CODON_TABLE[{first_q[1:0], second_q[1:0], base[1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.codon_step && (pos_q == 2'd0)) begin
			first_q <= base;
		end
		if (ctl.codon_step && (pos_q == 2'd1)) begin
			second_q <= base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.clear || (ctl.codon_step && is_third)) begin
			pos_q <= '0;
		end else if (ctl.codon_step) begin
			pos_q <= pos_q + 2'd1;
		end
	end

endmodule

// File: hw/rtl/marker_scan_codon_translator.sv
// ---------------------------------------------------------------------------
// Marker scan codon translator
// Finds a marker in a read and translates the following codons.
// ---------------------------------------------------------------------------
// The block takes one base per request together with a flag on the read's
// last base, and accepts a new base in every cycle as long as results are
// drained. A base is captured in an input register; from there the
// marker window compare and the codon table lookup update the per-read state
// and, when a codon completes or the read ends, load the result register.
// The sustained rate of one base per cycle, as long as results are
// drained, is set by the per-base state update (window shift with match,
// codon step, phase change) in the processing stage.
// Only bases after the first marker occurrence are translated; translation
// ends after the first stop codon, which is still reported, and a trailing
// partial codon is dropped. A marker that ends on the read's last base does
// not count. Bases with a code above 3 never match the marker and make
// their codon unknown. On the last base the result carries read_end and
// marker_found, and all per-read state clears. The marker pattern lies at
// byte address 0 of the register port; write it only while the block is
// idle. No clearing pass runs after reset.
// ---------------------------------------------------------------------------
module marker_scan_codon_translator #(
	parameter int MARKER_LENGTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Base request channel.
	input  logic        base_valid,
	output logic        base_ready,
	input  logic [2:0]  base_code,
	input  logic        last_base,
	// Result request channel.
	output logic        result_valid,
	input  logic        result_ready,
	output logic        amino_valid,
	output logic [4:0]  amino_code,
	output logic        read_end,
	output logic        marker_found,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mscan_pkg::*;

	// Configuration register.
	logic [15:0] marker_pattern_q;
	logic        reg_hit;

	// Input stage.
	logic        valid_s1;
	logic [2:0]  base_s1;
	logic        last_s1;

	// Working signals of the processing stage.
	logic [2:0]  base_clean;
	logic        fire;
	logic        has_result;
	logic        match;
	logic        codon_valid;
	logic        codon_done;
	logic [4:0]  codon_code;
	step_ctl_t   ctl;
	phase_t      phase_q;
	phase_t      phase_nxt;

	// Result register.
	logic        result_valid_q;
	logic        amino_valid_q;
	logic [4:0]  amino_code_q;
	logic        read_end_q;
	logic        marker_found_q;

	// -----------------------------------------------------------------------
	// Register port. Only word 0 exists; other words read as zero.
	// -----------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_MARKER_PATTERN);
	assign prdata  = reg_hit ? {16'd0, marker_pattern_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_pattern_q <= MARKER_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			marker_pattern_q <= pwdata[15:0];
		end
	end

	// -----------------------------------------------------------------------
	// Input register. It refills in the same cycle that its base moves on.
	// -----------------------------------------------------------------------
	assign base_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (base_ready) begin
			valid_s1 <= base_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (base_valid && base_ready) begin
			base_s1 <= base_code;
			last_s1 <= last_base;
		end
	end

	// -----------------------------------------------------------------------
	// Processing stage. A base that yields no result never waits on the
	// result register; one that does waits only while that register is full.
	// Whether a codon completes is known from the phase and the codon
	// position alone, before the base is allowed to move on.
	// -----------------------------------------------------------------------
	assign base_clean = (base_s1 > BASE_OTHER) ? BASE_OTHER : base_s1;
	assign codon_done = (phase_q == PH_TRANSLATE) && codon_valid;
	assign has_result = codon_done || last_s1;
	assign fire       = valid_s1 && (!has_result || !result_valid_q || result_ready);

	assign ctl.win_shift  = fire && (phase_q == PH_SEARCH);
	assign ctl.codon_step = fire && (phase_q == PH_TRANSLATE);
	assign ctl.clear      = fire && last_s1;

	mscan_window #(
		.MARKER_LENGTH (MARKER_LENGTH)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.base           (base_clean),
		.marker_pattern (marker_pattern_q),
		.match          (match)
	);

	mscan_codon u_codon (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.base        (base_clean),
		.amino_valid (codon_valid),
		.amino_code  (codon_code)
	);

	// Scan phase: search for the marker, translate, then wait for read end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		if (fire) begin
			if (last_s1) begin
				phase_nxt = PH_SEARCH;
			end else begin
				unique case (phase_q)
					PH_SEARCH: begin
						if (match) begin
							phase_nxt = PH_TRANSLATE;
						end
					end
					PH_TRANSLATE: begin
						if (codon_valid && (codon_code == AMINO_STOP)) begin
							phase_nxt = PH_STOPPED;
						end
					end
					PH_STOPPED: begin
						phase_nxt = PH_STOPPED;
					end
					default: begin
						phase_nxt = PH_SEARCH;
					end
				endcase
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result register. The marker counts as found once the scan has left
	// the search phase; a match on the last base never leaves it.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && has_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			amino_valid_q  <= codon_done;
			amino_code_q   <= codon_done ? codon_code : '0;
			read_end_q     <= last_s1;
			marker_found_q <= last_s1 && (phase_q != PH_SEARCH);
		end
	end

	assign result_valid = result_valid_q;
	assign amino_valid  = amino_valid_q;
	assign amino_code   = amino_code_q;
	assign read_end     = read_end_q;
	assign marker_found = marker_found_q;

endmodule

// File: hw/rtl/mscan_assert_chk.sv
// ---------------------------------------------------------------------------
// Marker scan codon translator port checker
// Watches the result channel of the top level and flags malformed results.
// ---------------------------------------------------------------------------
`include "marker_scan_codon_translator_assert.svh"

module mscan_assert_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic       amino_valid,
	input logic [4:0] amino_code,
	input logic       read_end,
	input logic       marker_found
);

	// Every result carries either an amino acid or the end of a read.
	`MSCAN_ASSERT_NOW(a_result_not_empty, result_valid, amino_valid || read_end)

	// The amino code is zero unless it carries a translated codon.
	`MSCAN_ASSERT_NOW(a_amino_zero, result_valid && !amino_valid, amino_code == 5'd0)

	// Translated codes stay within the amino acid, stop and unknown codes.
	`MSCAN_ASSERT_NOW(a_amino_range, result_valid && amino_valid, amino_code <= 5'd21)

	// The found flag only comes with the end of a read.
	`MSCAN_ASSERT_NOW(a_found_at_end, result_valid && !read_end, !marker_found)

	// A stalled result holds.
	`MSCAN_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(amino_code) && $stable(read_end) && $stable(marker_found))

endmodule

bind marker_scan_codon_translator mscan_assert_chk u_assert_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.amino_valid  (amino_valid),
	.amino_code   (amino_code),
	.read_end     (read_end),
	.marker_found (marker_found)
);
